// ===== hw/rtl/csh_pkg.sv =====
`default_nettype none

package csh_pkg;

    // field widths
    localparam int TAXON_W  = 32;
    localparam int COUNT_W  = 16;
    localparam int LEN_W    = 16;
    localparam int SEL_W    = 6;
    localparam int CMD_W    = 3;
    localparam int HIST_W   = 32;
    localparam int RCNT_W   = 32;
    localparam int SUM_W    = 48;
    localparam int AVG_W    = 24;
    localparam int FRAC_W   = 8;
    localparam int ADDED_W  = 7;

    // divider widths: Q.8 length sum over the read count
    localparam int DIV_W    = SUM_W + FRAC_W;
    localparam int DVS_W    = RCNT_W;
    localparam int STEP_W   = $clog2(DIV_W);

    // packed stream widths
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = CMD_W;
    localparam int OUT_DATA_W = 160;

    localparam int BIN_COUNT_DEF = 10;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ_START = 3'd0,
        CMD_HIT        = 3'd1,
        CMD_SEPARATOR  = 3'd2,
        CMD_END_READ   = 3'd3,
        CMD_READ_OUT   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/csh_div.sv =====
`default_nettype none

// restoring divider, one quotient bit a cycle
module csh_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire csh_pkg::t_div_req i_req,
    output csh_pkg::t_div_rsp      o_rsp
);
    import csh_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DIV_W-1:0]  r_quo;

    logic [DVS_W:0]    w_trial;
    logic              w_fits;
    logic [DVS_W:0]    w_diff;

    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_fits  = w_trial >= {1'b0, r_dvs};
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIV_W - 1);
                r_rem  <= '0;
                r_dvs  <= i_req.divisor;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= w_fits ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], w_fits};
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{busy: r_busy, done: r_done, quotient: r_quo};

endmodule

`default_nettype wire

// ===== hw/rtl/classification_score_histogram_unit.sv =====
`default_nettype none

// channel   direction  handshake                        payload
// s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata: taxon, hit count, lengths, bin
//                                                       tuser: command
// m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata: bin counts, total, averages,
//                                                       added bins
// cfg       in         i_cfg_valid/o_cfg_ready          target taxon
//
// hit token, separator, unknown command and an unselected read start go straight to the finishing step
// a read out adds one registered histogram read
// a selected read start runs two 56-step divisions for the averages
// an end of read runs at most one division and one read-modify-write per mate
// the shared restoring divider does all the divisions; one item is in work at a time
// reset (synchronous, active low) clears all sums, counts and histogram valid bits at once
// a stalled result sits in the output register; the next item is taken meanwhile but its
// result waits until the register is free

module classification_score_histogram_unit #(
    parameter int BIN_COUNT = csh_pkg::BIN_COUNT_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [csh_pkg::TAXON_W-1:0]    i_cfg_data,
    // input items
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // taxon_id[31:0], hit_count[47:32], forward_length[63:48], reverse_length[79:64],
    // bin_select[85:80], zero fill [87:86]
    input  wire logic [csh_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // command[2:0]
    input  wire logic [csh_pkg::IN_USER_W-1:0]  i_s_axis_tuser,
    // result items
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // forward_bin_count[31:0], reverse_bin_count[63:32], read_total[95:64],
    // forward_average[119:96], reverse_average[143:120], forward_bin_added[150:144],
    // reverse_bin_added[157:151], zero fill [159:158]
    output logic [csh_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);
    import csh_pkg::*;

    localparam int AW    = $clog2(BIN_COUNT);
    localparam int MUL_W = ADDED_W + COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_FA_DIV,
        S_RA_DIV,
        S_FB_DIV,
        S_FB_RD,
        S_FB_WR,
        S_RB_DIV,
        S_RB_RD,
        S_RB_WR,
        S_RO_RD,
        S_FINISH
    } t_state;

    t_state r_state;

    // latched item
    t_cmd               r_cmd;
    logic [TAXON_W-1:0] r_taxon;
    logic [COUNT_W-1:0] r_hit;
    logic [LEN_W-1:0]   r_flen;
    logic [LEN_W-1:0]   r_rlen;
    logic [SEL_W-1:0]   r_bin_sel;

    // summary state
    logic [TAXON_W-1:0] r_target;
    logic [RCNT_W-1:0]  r_read_cnt;
    logic [SUM_W-1:0]   r_fsum;
    logic [SUM_W-1:0]   r_rsum;
    logic [COUNT_W-1:0] r_fmat;
    logic [COUNT_W-1:0] r_ftot;
    logic [COUNT_W-1:0] r_rmat;
    logic [COUNT_W-1:0] r_rtot;
    logic               r_in_rev;
    logic               r_read_sel;
    // averages kept up to date after every selected read start
    logic [AVG_W-1:0]   r_favg;
    logic [AVG_W-1:0]   r_ravg;

    // per-item working registers
    logic [ADDED_W-1:0] r_fadded;
    logic [ADDED_W-1:0] r_radded;
    logic               r_ro_hit;
    logic [AW-1:0]      r_addr;

    // histograms: one address a cycle, registered read, valid bit per entry
    logic [HIST_W-1:0]    r_f_mem [BIN_COUNT];
    logic [HIST_W-1:0]    r_r_mem [BIN_COUNT];
    logic [BIN_COUNT-1:0] r_f_vld;
    logic [BIN_COUNT-1:0] r_r_vld;
    logic [HIST_W-1:0]    r_f_rd;
    logic [HIST_W-1:0]    r_r_rd;

    // result register
    logic               r_m_valid;
    logic [HIST_W-1:0]  r_o_fcnt;
    logic [HIST_W-1:0]  r_o_rcnt;
    logic [RCNT_W-1:0]  r_o_total;
    logic [AVG_W-1:0]   r_o_favg;
    logic [AVG_W-1:0]   r_o_ravg;
    logic [ADDED_W-1:0] r_o_fadded;
    logic [ADDED_W-1:0] r_o_radded;

    // shared divider
    t_div_req r_div_req;
    t_div_rsp w_div_rsp;

    csh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (w_div_rsp)
    );

    logic               w_accept;
    logic               w_out_free;
    logic               w_taxon_hit;
    logic [RCNT_W-1:0]  n_read_cnt;
    logic [SUM_W:0]     w_fsum_add;
    logic [SUM_W:0]     w_rsum_add;
    logic [SUM_W-1:0]   n_fsum;
    logic [SUM_W-1:0]   n_rsum;
    logic [COUNT_W:0]   w_tot_add;
    logic [COUNT_W:0]   w_mat_add;
    logic [COUNT_W-1:0] n_tot;
    logic [COUNT_W-1:0] n_mat;
    logic [MUL_W-1:0]   w_fprod;
    logic [MUL_W-1:0]   w_rprod;
    logic [AVG_W-1:0]   w_avg;
    logic [ADDED_W-1:0] w_bin;
    logic               w_sel_ok;
    logic               w_f_we;
    logic               w_r_we;
    logic [HIST_W-1:0]  n_f_hist;
    logic [HIST_W-1:0]  n_r_hist;

    always_comb begin
        w_accept    = i_s_axis_tvalid && o_s_axis_tready;
        w_out_free  = !r_m_valid || i_m_axis_tready;
        w_taxon_hit = r_taxon == r_target;

        n_read_cnt = (r_read_cnt == '1) ? r_read_cnt : r_read_cnt + 1'b1;
        w_fsum_add = {1'b0, r_fsum} + (SUM_W + 1)'(r_flen);
        w_rsum_add = {1'b0, r_rsum} + (SUM_W + 1)'(r_rlen);
        n_fsum     = w_fsum_add[SUM_W] ? '1 : w_fsum_add[SUM_W-1:0];
        n_rsum     = w_rsum_add[SUM_W] ? '1 : w_rsum_add[SUM_W-1:0];

        // the current mate's total and matches
        w_tot_add = {1'b0, (r_in_rev ? r_rtot : r_ftot)} + {1'b0, r_hit};
        w_mat_add = {1'b0, (r_in_rev ? r_rmat : r_fmat)} + {1'b0, r_hit};
        n_tot     = w_tot_add[COUNT_W] ? '1 : w_tot_add[COUNT_W-1:0];
        n_mat     = w_mat_add[COUNT_W] ? '1 : w_mat_add[COUNT_W-1:0];

        w_fprod = MUL_W'(ADDED_W'(BIN_COUNT)) * MUL_W'(r_fmat);
        w_rprod = MUL_W'(ADDED_W'(BIN_COUNT)) * MUL_W'(r_rmat);

        // clamps on the divider's quotient
        w_avg = (w_div_rsp.quotient[DIV_W-1:AVG_W] != '0) ? '1
                                                            : w_div_rsp.quotient[AVG_W-1:0];
        w_bin = (w_div_rsp.quotient >= DIV_W'(BIN_COUNT)) ? ADDED_W'(BIN_COUNT - 1)
                                                          : w_div_rsp.quotient[ADDED_W-1:0];

        w_sel_ok = {1'b0, r_bin_sel} < ADDED_W'(BIN_COUNT);

        w_f_we   = r_state == S_FB_WR;
        w_r_we   = r_state == S_RB_WR;
        n_f_hist = (r_f_rd == '1) ? r_f_rd : r_f_rd + 1'b1;
        n_r_hist = (r_r_rd == '1) ? r_r_rd : r_r_rd + 1'b1;
    end

    // histogram storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= '0;
            r_r_vld <= '0;
        end else begin
            if (w_f_we) begin
                r_f_vld[r_addr] <= 1'b1;
            end
            if (w_r_we) begin
                r_r_vld[r_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_f_we) begin
            r_f_mem[r_addr] <= n_f_hist;
        end
        if (w_r_we) begin
            r_r_mem[r_addr] <= n_r_hist;
        end
        r_f_rd <= r_f_vld[r_addr] ? r_f_mem[r_addr] : '0;
        r_r_rd <= r_r_vld[r_addr] ? r_r_mem[r_addr] : '0;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_m_valid       <= 1'b0;
            r_target        <= '0;
            r_read_cnt      <= '0;
            r_fsum          <= '0;
            r_rsum          <= '0;
            r_fmat          <= '0;
            r_ftot          <= '0;
            r_rmat          <= '0;
            r_rtot          <= '0;
            r_in_rev        <= 1'b0;
            r_read_sel      <= 1'b0;
            r_favg          <= '0;
            r_ravg          <= '0;
            r_div_req.start <= 1'b0;
        end else begin
            r_div_req.start <= 1'b0;

            if (i_cfg_valid) begin
                r_target <= i_cfg_data;
            end

            if (r_m_valid && i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cmd     <= t_cmd'(i_s_axis_tuser);
                        r_taxon   <= i_s_axis_tdata[31:0];
                        r_hit     <= i_s_axis_tdata[47:32];
                        r_flen    <= i_s_axis_tdata[63:48];
                        r_rlen    <= i_s_axis_tdata[79:64];
                        r_bin_sel <= i_s_axis_tdata[85:80];
                        r_state   <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    r_fadded <= ADDED_W'(BIN_COUNT);
                    r_radded <= ADDED_W'(BIN_COUNT);
                    r_ro_hit <= 1'b0;
                    r_state  <= S_FINISH;
                    unique case (r_cmd)
                        CMD_READ_START: begin
                            r_fmat     <= '0;
                            r_ftot     <= '0;
                            r_rmat     <= '0;
                            r_rtot     <= '0;
                            r_in_rev   <= 1'b0;
                            r_read_sel <= w_taxon_hit;
                            if (w_taxon_hit) begin
                                r_read_cnt         <= n_read_cnt;
                                r_fsum             <= n_fsum;
                                r_rsum             <= n_rsum;
                                r_div_req.start    <= 1'b1;
                                r_div_req.dividend <= {n_fsum, FRAC_W'(0)};
                                r_div_req.divisor  <= n_read_cnt;
                                r_state            <= S_FA_DIV;
                            end
                        end
                        CMD_HIT: begin
                            if (r_in_rev) begin
                                r_rtot <= n_tot;
                                if (w_taxon_hit) begin
                                    r_rmat <= n_mat;
                                end
                            end else begin
                                r_ftot <= n_tot;
                                if (w_taxon_hit) begin
                                    r_fmat <= n_mat;
                                end
                            end
                        end
                        CMD_SEPARATOR: begin
                            r_in_rev <= 1'b1;
                        end
                        CMD_END_READ: begin
                            // zero-total mates and unselected reads are not binned
                            if (r_read_sel && r_ftot != '0) begin
                                r_div_req.start    <= 1'b1;
                                r_div_req.dividend <= DIV_W'(w_fprod);
                                r_div_req.divisor  <= DVS_W'(r_ftot);
                                r_state            <= S_FB_DIV;
                            end else if (r_read_sel && r_rtot != '0) begin
                                r_div_req.start    <= 1'b1;
                                r_div_req.dividend <= DIV_W'(w_rprod);
                                r_div_req.divisor  <= DVS_W'(r_rtot);
                                r_state            <= S_RB_DIV;
                            end
                        end
                        CMD_READ_OUT: begin
                            r_ro_hit <= w_sel_ok;
                            r_addr   <= r_bin_sel[AW-1:0];
                            r_state  <= S_RO_RD;
                        end
                        default: begin
                        end
                    endcase
                end

                S_FA_DIV: begin
                    if (w_div_rsp.done) begin
                        r_favg             <= w_avg;
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= {r_rsum, FRAC_W'(0)};
                        r_div_req.divisor  <= r_read_cnt;
                        r_state            <= S_RA_DIV;
                    end
                end

                S_RA_DIV: begin
                    if (w_div_rsp.done) begin
                        r_ravg  <= w_avg;
                        r_state <= S_FINISH;
                    end
                end

                S_FB_DIV: begin
                    if (w_div_rsp.done) begin
                        r_fadded <= w_bin;
                        r_addr   <= w_bin[AW-1:0];
                        r_state  <= S_FB_RD;
                    end
                end

                S_FB_RD: begin
                    r_state <= S_FB_WR;
                end

                S_FB_WR: begin
                    if (r_rtot != '0) begin
                        r_div_req.start    <= 1'b1;
                        r_div_req.dividend <= DIV_W'(w_rprod);
                        r_div_req.divisor  <= DVS_W'(r_rtot);
                        r_state            <= S_RB_DIV;
                    end else begin
                        r_state <= S_FINISH;
                    end
                end

                S_RB_DIV: begin
                    if (w_div_rsp.done) begin
                        r_radded <= w_bin;
                        r_addr   <= w_bin[AW-1:0];
                        r_state  <= S_RB_RD;
                    end
                end

                S_RB_RD: begin
                    r_state <= S_RB_WR;
                end

                S_RB_WR: begin
                    r_state <= S_FINISH;
                end

                S_RO_RD: begin
                    r_state <= S_FINISH;
                end

                S_FINISH: begin
                    if (w_out_free) begin
                        r_m_valid  <= 1'b1;
                        r_o_fcnt   <= (r_cmd == CMD_READ_OUT && r_ro_hit) ? r_f_rd : '0;
                        r_o_rcnt   <= (r_cmd == CMD_READ_OUT && r_ro_hit) ? r_r_rd : '0;
                        r_o_total  <= r_read_cnt;
                        r_o_favg   <= r_favg;
                        r_o_ravg   <= r_ravg;
                        r_o_fadded <= r_fadded;
                        r_o_radded <= r_radded;
                        if (r_cmd == CMD_END_READ) begin
                            r_fmat     <= '0;
                            r_ftot     <= '0;
                            r_rmat     <= '0;
                            r_rtot     <= '0;
                            r_in_rev   <= 1'b0;
                            r_read_sel <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = r_state == S_IDLE;
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {2'b00, r_o_radded, r_o_fadded, r_o_ravg, r_o_favg,
                              r_o_total, r_o_rcnt, r_o_fcnt};

    // an item is only taken while the divider is free
    a_accept_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_div_rsp.busy)
        else $error("item accepted while divider busy");

    // a result only appears out of the finishing step
    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == S_FINISH))
        else $error("result raised outside finishing step");

    // the read counter never goes back
    a_read_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_read_cnt >= $past(r_read_cnt))
        else $error("read counter decreased");

    // an added bin is a real bin or the none code
    a_added_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_o_fadded <= ADDED_W'(BIN_COUNT)) && (r_o_radded <= ADDED_W'(BIN_COUNT)))
        else $error("added bin out of range");

endmodule

`default_nettype wire
